[design/vtbe_pkg.sv]
`default_nettype none

package vtbe_pkg;

    // Stream geometry
    localparam int COORD_W    = 14;
    localparam int COLOR_W    = 4;
    localparam int CMD_W      = 3;
    localparam int IN_BITS    = 4 * COORD_W + COLOR_W;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int PT_W       = 10;
    localparam int MAX_BYTES  = 9;
    localparam int CNT_W      = $clog2(MAX_BYTES + 1);
    localparam int CFG_IDX_W  = 2;

    typedef logic [7:0]                  octet_t;
    typedef logic [PT_W-1:0]             pt_t;
    typedef logic [CNT_W-1:0]            cnt_t;
    typedef logic [MAX_BYTES-1:0][7:0]   byte_list_t;
    typedef logic [3:0][7:0]             point_bytes_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_LINE       = 3'd0,
        CMD_BEGIN_PAGE = 3'd1,
        CMD_END_PAGE   = 3'd2,
        CMD_SET_COLOR  = 3'd3,
        CMD_TEXT       = 3'd4,
        CMD_GRAPHICS   = 3'd5
    } cmd_e;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IS_TERMINAL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DUAL_SCREEN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_ENABLED = 2'd2;

    typedef struct packed {
        logic is_terminal;
        logic dual_screen;
        logic color_enabled;
    } cfg_t;

    typedef struct packed {
        pt_t  prev_x;
        pt_t  prev_y;
        logic prev_valid;
        logic gfx_screen;
    } enc_state_t;

    // Control characters
    localparam octet_t CH_ETX   = 8'd3;
    localparam octet_t CH_BEL   = 8'd7;
    localparam octet_t CH_FF    = 8'd12;
    localparam octet_t CH_CAN   = 8'd24;
    localparam octet_t CH_ESC   = 8'd27;
    localparam octet_t CH_GS    = 8'd29;
    localparam octet_t CH_US    = 8'd31;
    localparam octet_t CH_M     = 8'd77;
    localparam octet_t CH_L     = 8'd76;
    localparam octet_t CH_LBRK  = 8'd91;
    localparam octet_t CH_QMARK = 8'd63;
    localparam octet_t CH_3     = 8'd51;
    localparam octet_t CH_8     = 8'd56;
    localparam octet_t CH_H     = 8'd104;

    // Address byte offsets
    localparam octet_t HI_OFS    = 8'd32;
    localparam octet_t LO_Y_OFS  = 8'd96;
    localparam octet_t LO_X_OFS  = 8'd64;
    localparam octet_t COLOR_OFS = 8'd48;

    // Four address bytes of a point, element 0 goes out first
    function automatic point_bytes_t point_bytes(pt_t x, pt_t y);
        point_bytes_t b;
        b[0] = octet_t'(y[PT_W-1:5]) + HI_OFS;
        b[1] = octet_t'(y[4:0]) + LO_Y_OFS;
        b[2] = octet_t'(x[PT_W-1:5]) + HI_OFS;
        b[3] = octet_t'(x[4:0]) + LO_X_OFS;
        return b;
    endfunction

endpackage

`default_nettype wire

[design/vtbe_compose.sv]
`default_nettype none

// Builds the byte list for one request and the encoder state after it
module vtbe_compose #(
    parameter int COORD_SHIFT = 4
) (
    input  logic [vtbe_pkg::CMD_W-1:0]   cmd,
    input  logic [vtbe_pkg::COORD_W-1:0] start_x,
    input  logic [vtbe_pkg::COORD_W-1:0] start_y,
    input  logic [vtbe_pkg::COORD_W-1:0] end_x,
    input  logic [vtbe_pkg::COORD_W-1:0] end_y,
    input  logic [vtbe_pkg::COLOR_W-1:0] color_index,
    input  vtbe_pkg::cfg_t               cfg,
    input  vtbe_pkg::enc_state_t         state_cur,
    output vtbe_pkg::byte_list_t         bytes,
    output vtbe_pkg::cnt_t               count,
    output vtbe_pkg::enc_state_t         state_next
);
    import vtbe_pkg::*;

    logic [COORD_W-1:0] sx_w, sy_w, ex_w, ey_w;
    pt_t                sx, sy, ex, ey;
    point_bytes_t       start_pt, end_pt;
    logic               same_start;

    // Scale coordinates, keep the low address bits
    assign sx_w = start_x >> COORD_SHIFT;
    assign sy_w = start_y >> COORD_SHIFT;
    assign ex_w = end_x >> COORD_SHIFT;
    assign ey_w = end_y >> COORD_SHIFT;
    assign sx   = sx_w[PT_W-1:0];
    assign sy   = sy_w[PT_W-1:0];
    assign ex   = ex_w[PT_W-1:0];
    assign ey   = ey_w[PT_W-1:0];

    assign start_pt   = point_bytes(sx, sy);
    assign end_pt     = point_bytes(ex, ey);
    assign same_start = state_cur.prev_valid && (sx == state_cur.prev_x)
                        && (sy == state_cur.prev_y);

    always_comb begin
        bytes      = '0;
        count      = '0;
        state_next = state_cur;
        case (cmd_e'(cmd))
            CMD_LINE: begin
                if (same_start) begin
                    bytes[3:0] = end_pt;
                    count      = cnt_t'(4);
                end else begin
                    bytes[0]   = CH_GS;
                    bytes[4:1] = start_pt;
                    bytes[8:5] = end_pt;
                    count      = cnt_t'(9);
                end
                state_next.prev_x     = ex;
                state_next.prev_y     = ey;
                state_next.prev_valid = 1'b1;
            end
            CMD_BEGIN_PAGE: begin
                state_next.prev_valid = 1'b0;
            end
            CMD_END_PAGE: begin
                if (cfg.is_terminal) begin
                    bytes[0] = CH_BEL;
                    bytes[1] = CH_ESC;
                    bytes[2] = CH_FF;
                    count    = cnt_t'(3);
                end else begin
                    bytes[0] = CH_ESC;
                    bytes[1] = CH_FF;
                    count    = cnt_t'(2);
                end
            end
            CMD_SET_COLOR: begin
                if (cfg.color_enabled) begin
                    bytes[0] = CH_ESC;
                    bytes[1] = CH_M;
                    bytes[2] = CH_L;
                    bytes[3] = octet_t'(color_index) + COLOR_OFS;
                    count    = cnt_t'(4);
                end
            end
            CMD_TEXT: begin
                if (cfg.is_terminal && state_cur.gfx_screen) begin
                    state_next.gfx_screen = 1'b0;
                    if (cfg.dual_screen) begin
                        bytes[0] = CH_US;
                        bytes[1] = CH_CAN;
                        bytes[2] = CH_ESC;
                        bytes[3] = CH_ETX;
                        bytes[4] = CH_US;
                        bytes[5] = CH_CAN;
                        count    = cnt_t'(6);
                    end else begin
                        bytes[0] = CH_US;
                        count    = cnt_t'(1);
                    end
                end
            end
            CMD_GRAPHICS: begin
                if (cfg.is_terminal && !state_cur.gfx_screen) begin
                    state_next.gfx_screen = 1'b1;
                    if (cfg.dual_screen) begin
                        bytes[0] = CH_ESC;
                        bytes[1] = CH_LBRK;
                        bytes[2] = CH_QMARK;
                        bytes[3] = CH_3;
                        bytes[4] = CH_8;
                        bytes[5] = CH_H;
                        count    = cnt_t'(6);
                    end else begin
                        bytes[0] = CH_GS;
                        count    = cnt_t'(1);
                    end
                end
            end
            default: begin
                // unused codes: no bytes, no state change
            end
        endcase
    end

endmodule

`default_nettype wire

[design/vtbe_serializer.sv]
`default_nettype none

// Output shift register: sends a loaded byte list one byte per cycle while m_tready is high
module vtbe_serializer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  vtbe_pkg::byte_list_t bytes,
    input  vtbe_pkg::cnt_t       count,
    output logic                 free,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [7:0] out_byte
    output logic                 m_tlast
);
    import vtbe_pkg::*;

    byte_list_t list_reg;
    cnt_t       rem_reg;
    logic       take;

    assign m_tvalid = (rem_reg != '0);
    assign m_tdata  = list_reg[0];
    assign m_tlast  = (rem_reg == cnt_t'(1));
    assign take     = m_tvalid && m_tready;
    // empty now, or the final byte leaves this cycle
    assign free     = !m_tvalid || (m_tlast && m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
        end else if (load) begin
            rem_reg <= count;
        end else if (take) begin
            rem_reg <= rem_reg - cnt_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            list_reg <= bytes;
        end else if (take) begin
            list_reg <= {8'h00, list_reg[MAX_BYTES-1:1]};
        end
    end

endmodule

`default_nettype wire

[design/vector_terminal_byte_encoder_unit.sv]
`default_nettype none

// Vector terminal byte encoder. Drawing requests (line, begin page, end page,
// set color, text mode, graphics mode) enter on the s_ stream and leave as the
// terminal's graphics byte stream on the m_ stream, one byte per transfer, with
// m_tlast on the final byte of each request; requests that produce nothing send
// no transfer. A request is taken into an input register and may be accepted
// while earlier bytes are still going out. A request is handed to the output
// shift register once the one before has sent its final byte or sends it in
// the same cycle. A request sends 9 bytes for a line whose start differs from
// the last point, 4 for a joined line and 0 to 6 for the other requests. That
// shift register sets the sustained rate. Configuration must be written only
// while the block is idle.
module vector_terminal_byte_encoder_unit #(
    parameter int COORD_SHIFT = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [13:0] start_x, [27:14] start_y, [41:28] end_x, [55:42] end_y,
    // [59:56] color_index, [63:60] zero
    input  logic [vtbe_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic [vtbe_pkg::CMD_W-1:0]          s_tuser,   // [2:0] command
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,   // [7:0] out_byte
    output logic                                m_tlast,   // last_byte
    input  logic                                cfg_wr_en,
    input  logic [vtbe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic                                cfg_wdata
);
    import vtbe_pkg::*;

    logic                  in_valid_reg;
    logic [CMD_W-1:0]      in_cmd_reg;
    logic [IN_TDATA_W-1:0] in_data_reg;
    cfg_t                  cfg_reg;
    enc_state_t            state_reg;
    enc_state_t            state_next;
    byte_list_t            bytes;
    cnt_t                  count;
    logic                  ser_free;
    logic                  load;

    // Input register hands over when the serializer can take the list
    assign load     = in_valid_reg && ser_free;
    assign s_tready = !in_valid_reg || load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_cmd_reg  <= s_tuser;
            in_data_reg <= s_tdata;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.is_terminal   <= 1'b1;
            cfg_reg.dual_screen   <= 1'b0;
            cfg_reg.color_enabled <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_IS_TERMINAL:   cfg_reg.is_terminal   <= cfg_wdata;
                REG_DUAL_SCREEN:   cfg_reg.dual_screen   <= cfg_wdata;
                REG_COLOR_ENABLED: cfg_reg.color_enabled <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Last point and screen mode advance as each request is handed over
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.prev_x     <= '0;
            state_reg.prev_y     <= '0;
            state_reg.prev_valid <= 1'b0;
            state_reg.gfx_screen <= 1'b1;
        end else if (load) begin
            state_reg <= state_next;
        end
    end

    vtbe_compose #(
        .COORD_SHIFT (COORD_SHIFT)
    ) u_compose (
        .cmd         (in_cmd_reg),
        .start_x     (in_data_reg[COORD_W-1:0]),
        .start_y     (in_data_reg[2*COORD_W-1:COORD_W]),
        .end_x       (in_data_reg[3*COORD_W-1:2*COORD_W]),
        .end_y       (in_data_reg[4*COORD_W-1:3*COORD_W]),
        .color_index (in_data_reg[4*COORD_W+COLOR_W-1:4*COORD_W]),
        .cfg         (cfg_reg),
        .state_cur   (state_reg),
        .bytes       (bytes),
        .count       (count),
        .state_next  (state_next)
    );

    vtbe_serializer u_serializer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .bytes    (bytes),
        .count    (count),
        .free     (ser_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

[design/vtbe_checker.sv]
`default_nettype none

// Port-level checks on the encoder's output stream
module vtbe_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);
    import vtbe_pkg::*;

    // nothing goes out in the cycle after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    // a stalled byte is held
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output byte dropped or changed");

    // BEL and ESC never end a sequence
    a_esc_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata == CH_ESC || m_tdata == CH_BEL) |-> !m_tlast)
        else $error("escape or bell marked as final byte");

    // form feed only closes an end of page
    a_ff_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata == CH_FF) |-> m_tlast)
        else $error("form feed not marked as final byte");

endmodule

bind vector_terminal_byte_encoder_unit vtbe_checker u_vtbe_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
